// ===== hdl/fmp_pkg.sv =====
package fmp_pkg;

    // Default width of the wrapped result
    localparam int VALUE_BITS_DEF = 128;

    // Multiplier limb width and output half width
    localparam int LIMB_W = 32;
    localparam int HALF_W = 64;

    // Index field and the bit counter that walks it
    localparam int INDEX_W = 8;
    localparam int CNT_W   = $clog2(INDEX_W);

    // Sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SETUP,
        ST_LOOP,
        ST_MUL_AA,
        ST_MUL_BB,
        ST_MUL_BX,
        ST_STEP,
        ST_DONE
    } fmp_state_t;

    // Status of the shared multiplier
    typedef struct packed {
        logic busy;
        logic done;
    } fmp_mul_stat_t;

endpackage

// ===== hdl/fibonacci_matrix_power.sv =====
// Index 0 goes straight from idle to done; any other index passes through setup and the
// loop, which squares once per bit below the top set bit of index-1 before done.
// One index at a time; the next is taken the cycle after the result is registered, and
// out_stall can hold the result in the done state before that.
// Each bit costs three wide products on one 32x32 multiplier.
// Reset (rst_n, async, active low) returns the sequencer to idle and drops out_valid.
module fibonacci_matrix_power
    import fmp_pkg::*;
#(
    parameter int VALUE_BITS = VALUE_BITS_DEF
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [INDEX_W-1:0] index,
    output logic               out_valid,
    input  logic               out_stall,
    output logic [HALF_W-1:0]  value_low,
    output logic [HALF_W-1:0]  value_high
);

    fmp_state_t            state_reg;
    fmp_state_t            state_next;
    logic [CNT_W-1:0]      cnt_reg;
    logic [INDEX_W-1:0]    k_reg;
    logic                  out_valid_reg;
    logic [VALUE_BITS-1:0] res_reg;

    // Matrix power is [[a,b],[b,a-b]]; only a and b are kept
    logic [VALUE_BITS-1:0] a_reg;
    logic [VALUE_BITS-1:0] b_reg;
    logic [VALUE_BITS-1:0] aa_reg;
    logic [VALUE_BITS-1:0] bb_reg;

    logic                  mul_start;
    logic [VALUE_BITS-1:0] op_a;
    logic [VALUE_BITS-1:0] op_b;
    logic [VALUE_BITS-1:0] product;
    fmp_mul_stat_t         mul_stat;
    logic [CNT_W-1:0]      top_bit;
    logic                  out_load;

    fmp_wide_mul #(
        .VALUE_BITS (VALUE_BITS)
    ) u_mul (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (mul_start),
        .op_a    (op_a),
        .op_b    (op_b),
        .product (product),
        .stat    (mul_stat)
    );

    // Position of the highest set bit of the exponent
    always_comb
    begin
        top_bit = '0;
        for (int i = 0; i < INDEX_W; i++)
        begin
            if (k_reg[i])
            begin
                top_bit = CNT_W'(i);
            end
        end
    end

    assign out_load = (state_reg == ST_DONE) && (!out_valid_reg || !out_stall);

    // Next state, multiplier launch and operand select
    // Square: a' = a*a + b*b, b' = b*(2a - b)
    always_comb
    begin
        state_next = state_reg;
        mul_start  = 1'b0;
        op_a       = a_reg;
        op_b       = a_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = (index == '0) ? ST_DONE : ST_SETUP;
                end
            end
            ST_SETUP:
            begin
                state_next = ST_LOOP;
            end
            ST_LOOP:
            begin
                if (cnt_reg == '0)
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    mul_start  = 1'b1;
                    state_next = ST_MUL_AA;
                end
            end
            ST_MUL_AA:
            begin
                op_a = b_reg;
                op_b = b_reg;
                if (mul_stat.done)
                begin
                    mul_start  = 1'b1;
                    state_next = ST_MUL_BB;
                end
            end
            ST_MUL_BB:
            begin
                op_a = b_reg;
                op_b = (a_reg << 1) - b_reg;
                if (mul_stat.done)
                begin
                    mul_start  = 1'b1;
                    state_next = ST_MUL_BX;
                end
            end
            ST_MUL_BX:
            begin
                if (mul_stat.done)
                begin
                    state_next = ST_STEP;
                end
            end
            ST_STEP:
            begin
                state_next = ST_LOOP;
            end
            ST_DONE:
            begin
                if (out_load)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == ST_SETUP)
            begin
                cnt_reg <= top_bit;
            end
            else if (state_reg == ST_STEP)
            begin
                cnt_reg <= cnt_reg - CNT_W'(1);
            end
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && !out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Matrix entries and result register
    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    a_reg <= VALUE_BITS'(index != '0);
                    b_reg <= VALUE_BITS'(index != '0);
                    k_reg <= index - INDEX_W'(1);
                end
            end
            ST_MUL_AA:
            begin
                if (mul_stat.done)
                begin
                    aa_reg <= product;
                end
            end
            ST_MUL_BB:
            begin
                if (mul_stat.done)
                begin
                    bb_reg <= product;
                end
            end
            ST_MUL_BX:
            begin
                if (mul_stat.done)
                begin
                    a_reg <= aa_reg + bb_reg;
                    b_reg <= product;
                end
            end
            ST_STEP:
            begin
                // multiply by the base matrix when the exponent bit is set
                if (k_reg[cnt_reg - CNT_W'(1)])
                begin
                    a_reg <= a_reg + b_reg;
                    b_reg <= a_reg;
                end
            end
            ST_DONE:
            begin
                if (out_load)
                begin
                    res_reg <= a_reg;
                end
            end
            default:
            begin
            end
        endcase
    end

    assign in_stall   = (state_reg != ST_IDLE);
    assign out_valid  = out_valid_reg;
    assign value_low  = HALF_W'(res_reg);
    assign value_high = HALF_W'(res_reg >> HALF_W);

    // A new transaction never lands on a running multiply
    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |-> !mul_stat.busy)
        else $error("input accepted while multiplier busy");

    // Multiplier completion only while the sequencer waits on it
    a_done_in_mul: assert property (@(posedge clk) disable iff (!rst_n)
        mul_stat.done |-> (state_reg == ST_MUL_AA || state_reg == ST_MUL_BB
                           || state_reg == ST_MUL_BX))
        else $error("multiplier done outside a multiply state");

    // A result only appears from the done state
    a_out_from_done: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(state_reg == ST_DONE))
        else $error("out_valid rose outside done state");

    // Index zero goes straight to the result
    a_zero_direct: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall && index == '0) |=> (state_reg == ST_DONE))
        else $error("index zero did not bypass the loop");

endmodule

// ===== hdl/fmp_wide_mul.sv =====
module fmp_wide_mul
    import fmp_pkg::*;
#(
    parameter int VALUE_BITS = VALUE_BITS_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  logic [VALUE_BITS-1:0] op_a,
    input  logic [VALUE_BITS-1:0] op_b,
    output logic [VALUE_BITS-1:0] product,
    output fmp_mul_stat_t         stat
);

    localparam int LIMBS = (VALUE_BITS + LIMB_W - 1) / LIMB_W;
    localparam int PAD_W = LIMBS * LIMB_W;
    localparam int IDX_W = $clog2(LIMBS);
    localparam int PP_W  = 2 * LIMB_W;
    localparam int SH_W  = PAD_W + PP_W;

    logic [PAD_W-1:0]      a_reg;
    logic [PAD_W-1:0]      b_reg;
    logic [IDX_W-1:0]      i_reg;
    logic [IDX_W-1:0]      j_reg;
    logic [IDX_W-1:0]      sh_reg;
    logic                  issue_reg;
    logic                  pp_vld_reg;
    logic                  pp_last_reg;
    logic                  done_reg;
    logic [PP_W-1:0]       pp_reg;
    logic [VALUE_BITS-1:0] acc_reg;

    logic [LIMB_W-1:0]     a_limb;
    logic [LIMB_W-1:0]     b_limb;
    logic                  i_last;
    logic                  j_last;
    logic [SH_W-1:0]       pp_shifted;

    // Limb select and schedule end tests (only pairs with i+j < LIMBS matter mod 2^VALUE_BITS)
    always_comb
    begin
        a_limb     = a_reg[i_reg*LIMB_W +: LIMB_W];
        b_limb     = b_reg[j_reg*LIMB_W +: LIMB_W];
        i_last     = (i_reg == IDX_W'(LIMBS - 1));
        j_last     = (j_reg == IDX_W'(LIMBS - 1) - i_reg);
        pp_shifted = SH_W'(pp_reg) << (sh_reg * LIMB_W);
    end

    // Schedule control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            issue_reg   <= 1'b0;
            pp_vld_reg  <= 1'b0;
            pp_last_reg <= 1'b0;
            done_reg    <= 1'b0;
            i_reg       <= '0;
            j_reg       <= '0;
        end
        else
        begin
            done_reg    <= pp_vld_reg && pp_last_reg;
            pp_vld_reg  <= issue_reg;
            pp_last_reg <= issue_reg && i_last && j_last;
            if (start)
            begin
                issue_reg <= 1'b1;
                i_reg     <= '0;
                j_reg     <= '0;
            end
            else if (issue_reg)
            begin
                if (j_last)
                begin
                    if (i_last)
                    begin
                        issue_reg <= 1'b0;
                    end
                    else
                    begin
                        i_reg <= i_reg + IDX_W'(1);
                        j_reg <= '0;
                    end
                end
                else
                begin
                    j_reg <= j_reg + IDX_W'(1);
                end
            end
        end
    end

    // Partial product stage, then shifted accumulate
    always_ff @(posedge clk)
    begin
        if (issue_reg)
        begin
            pp_reg <= PP_W'(a_limb) * PP_W'(b_limb);
            sh_reg <= i_reg + j_reg;
        end
        if (start)
        begin
            a_reg   <= PAD_W'(op_a);
            b_reg   <= PAD_W'(op_b);
            acc_reg <= '0;
        end
        else if (pp_vld_reg)
        begin
            acc_reg <= acc_reg + pp_shifted[VALUE_BITS-1:0];
        end
    end

    assign product   = acc_reg;
    assign stat.busy = issue_reg | pp_vld_reg;
    assign stat.done = done_reg;

endmodule

// ===== test/fibonacci_matrix_power_tb.sv =====
module fibonacci_matrix_power_tb;
    import fmp_pkg::*;

    localparam int VALUE_BITS = VALUE_BITS_DEF;
    localparam logic [127:0] VALUE_MASK =
        (VALUE_BITS >= 128) ? {128{1'b1}} : ((128'd1 << VALUE_BITS) - 128'd1);

    // Allow margin after the last result
    localparam int SETTLE_CYCLES = 400;
    localparam int CYCLE_LIMIT   = 3_000_000;
    localparam int RANDOM_ITEMS  = 540;
    localparam int MAX_REPORTS   = 10;

    typedef struct packed {
        logic [127:0] e00;
        logic [127:0] e01;
        logic [127:0] e10;
        logic [127:0] e11;
    } fib_mat_t;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               in_valid = 1'b0;
    logic               in_stall;
    logic [INDEX_W-1:0] index = '0;
    logic               out_valid;
    logic               out_stall = 1'b0;
    logic [HALF_W-1:0]  value_low;
    logic [HALF_W-1:0]  value_high;

    // Expected F(n) values in order of acceptance
    logic [127:0] fib_expected_q[$];

    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int hold_request  = 0;
    int hold_left     = 0;
    int cycle_count   = 0;
    int sent_count    = 0;
    int checked_count = 0;
    int error_count   = 0;

    fibonacci_matrix_power #(
        .VALUE_BITS (VALUE_BITS)
    ) i_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .index      (index),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .value_low  (value_low),
        .value_high (value_high)
    );

    // Clock
    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // 2x2 matrix product, entries wrap at 128 bits
    function automatic fib_mat_t fib_mat_mul(input fib_mat_t x, input fib_mat_t y);
        fib_mat_t r;
        r.e00 = x.e00 * y.e00 + x.e01 * y.e10;
        r.e01 = x.e00 * y.e01 + x.e01 * y.e11;
        r.e10 = x.e10 * y.e00 + x.e11 * y.e10;
        r.e11 = x.e10 * y.e01 + x.e11 * y.e11;
        return r;
    endfunction

    // F(n) by square-and-multiply over the bits of n-1, high bit first
    function automatic logic [127:0] fib_by_matrix(input logic [INDEX_W-1:0] n);
        fib_mat_t           base;
        fib_mat_t           acc;
        logic [INDEX_W-1:0] k;
        int                 top;
        if (n == '0)
            return '0;
        base = '{e00: 128'd1, e01: 128'd1, e10: 128'd1, e11: 128'd0};
        acc  = base;
        k    = n - 1'b1;
        top  = -1;
        for (int b = INDEX_W - 1; b >= 0; b--)
        begin
            if (k[b] && top < 0)
                top = b;
        end
        for (int b = top - 1; b >= 0; b--)
        begin
            acc = fib_mat_mul(acc, acc);
            if (k[b])
                acc = fib_mat_mul(acc, base);
        end
        return acc.e00 & VALUE_MASK;
    endfunction

    // Output stall: random idling, or a long hold-off when one is requested
    always @(posedge clk)
    begin
        if (hold_request != 0)
        begin
            hold_left    = hold_request;
            hold_request = 0;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            out_stall <= 1'b1;
        end
        else
        begin
            out_stall <= ($urandom_range(99) < recv_idle_pct);
        end
    end

    // Result checker
    always @(posedge clk)
    begin
        logic [127:0] exp_value;
        if (rst_n && out_valid && !out_stall)
        begin
            if (fib_expected_q.size() == 0)
            begin
                error_count++;
                if (error_count <= MAX_REPORTS)
                    $display("unexpected result: value_high=%h value_low=%h",
                             value_high, value_low);
            end
            else
            begin
                exp_value = fib_expected_q.pop_front();
                checked_count++;
                if (value_low !== exp_value[63:0] || value_high !== exp_value[127:64])
                begin
                    error_count++;
                    if (error_count <= MAX_REPORTS)
                        $display("mismatch: expected high=%h low=%h, got high=%h low=%h",
                                 exp_value[127:64], exp_value[63:0], value_high, value_low);
                end
            end
        end
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, fib_expected_q.size());
            $display("fibonacci_matrix_power_tb failed");
            $finish;
        end
    end

    // Send one index; returns at the edge where the transaction is accepted
    task automatic send_index(input logic [INDEX_W-1:0] n);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        index    <= n;
        do
            @(posedge clk);
        while (in_stall);
        fib_expected_q.push_back(fib_by_matrix(n));
        sent_count++;
    endtask

    task automatic wait_results_drained();
        while (fib_expected_q.size() != 0)
            @(posedge clk);
    endtask

    // Edge indices, single-bit and alternating patterns, wrap boundary
    task automatic test_directed();
        logic [INDEX_W-1:0] picks[$];
        picks = '{8'd0, 8'd1, 8'd2, 8'd3, 8'd4, 8'd5, 8'd8, 8'd9, 8'd16, 8'd17,
                  8'd32, 8'd33, 8'd64, 8'd65, 8'd127, 8'd128, 8'd129, 8'h55,
                  8'hAA, 8'd186, 8'd187, 8'd254, 8'd255};
        send_idle_pct = 20;
        recv_idle_pct = 20;
        foreach (picks[i])
            send_index(picks[i]);
    endtask

    // Random indices, with some weight on the boundary values
    task automatic test_random(input int s_idle, input int r_idle, input int count);
        logic [INDEX_W-1:0] edges[$];
        logic [INDEX_W-1:0] n;
        edges = '{8'd0, 8'd1, 8'd2, 8'd186, 8'd187, 8'd255};
        send_idle_pct = s_idle;
        recv_idle_pct = r_idle;
        repeat (count)
        begin
            if ($urandom_range(7) == 0)
                n = edges[$urandom_range(edges.size() - 1)];
            else
                n = INDEX_W'($urandom_range(255));
            send_index(n);
        end
    endtask

    // Receiver holds off long enough that the block backs up into its input
    task automatic test_output_hold();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_request  = 600;
        repeat (8)
            send_index(INDEX_W'($urandom_range(255)));
    endtask

    // Sender stops until every outstanding result is back, then resumes
    task automatic test_sender_pause();
        send_idle_pct = 10;
        recv_idle_pct = 30;
        repeat (6)
            send_index(INDEX_W'($urandom_range(255)));
        in_valid <= 1'b0;
        @(posedge clk);
        wait_results_drained();
        repeat (6)
            send_index(INDEX_W'($urandom_range(255)));
    endtask

    // Test sequence
    initial
    begin
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_output_hold();
        test_sender_pause();
        test_random(35, 47, RANDOM_ITEMS);
        test_random(47, 35, RANDOM_ITEMS);
        test_random(0, 0, RANDOM_ITEMS);

        in_valid <= 1'b0;
        recv_idle_pct = 0;
        @(posedge clk);
        wait_results_drained();
        repeat (SETTLE_CYCLES) @(posedge clk);

        if (fib_expected_q.size() != 0)
        begin
            $display("%0d expected results never arrived", fib_expected_q.size());
            error_count += fib_expected_q.size();
        end

        $display("sent %0d indices, checked %0d results in %0d cycles", sent_count,
                 checked_count, cycle_count);
        $display("covered edge indices, both idle mixes, a long output hold-off, %0d errors",
                 error_count);
        if (error_count == 0)
            $display("fibonacci_matrix_power_tb passed");
        else
            $display("fibonacci_matrix_power_tb failed");
        $finish;
    end

endmodule
